FILE: hdl/windowed_tick_statistics_assert.svh
// assertion macros shared by the windowed tick statistics rtl
// no dependencies; each macro expands to nothing when SYNTHESIS is defined
`ifndef WINDOWED_TICK_STATISTICS_ASSERT_SVH
`define WINDOWED_TICK_STATISTICS_ASSERT_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define WTS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define WTS_ASSERT(label, clk, rst_n, prop, msg)
`endif

`ifndef SYNTHESIS
// checked at every edge, reset included
`define WTS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WTS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: hdl/wts_pkg.sv
// shared constants, opcodes, controller states and control structs
// for the windowed tick statistics block; no dependencies
package wts_pkg;

  localparam int WINDOW     = 16;
  localparam int CATEGORIES = 8;

  localparam int OP_W   = 2;
  localparam int CAT_W  = 3;
  localparam int TICK_W = 16;

  localparam int IN_DATA_W  = ((CAT_W + TICK_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((TICK_W + 7) / 8) * 8;

  localparam int PTR_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CAT_IDX_W = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;
  localparam int MEM_DEPTH = CATEGORIES * WINDOW;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // running sum of one ring
  localparam int SUM_W = TICK_W + $clog2(WINDOW + 1);

  // floor(sum / WINDOW) = (sum * RECIP) >> RECIP_SHIFT, exact for any SUM_W-bit sum
  localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W     = SUM_W + 1;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
  localparam int PROD_W = SUM_W + RECIP_W;

  typedef enum logic [OP_W-1:0] {
    OP_RECORD = 2'd0,
    OP_MIN    = 2'd1,
    OP_AVG    = 2'd2,
    OP_MAX    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DRAIN,
    ST_CALC,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic load;      // capture the accepted word, clear scan state
    logic write;     // store the captured duration in its ring
    logic read;      // read the slot at the scan index
    logic out_load;  // move the statistic into the output register
  } cmd_t;

  typedef struct packed {
    logic in_rec;    // word offered at the input is a record
    logic last_slot; // scan index points at the final slot
    logic out_free;  // output register can take a new word
  } sts_t;

endpackage

FILE: hdl/wts_ctrl.sv
// controller state machine for the windowed tick statistics block
// depends on wts_pkg and windowed_tick_statistics_assert.svh
`include "windowed_tick_statistics_assert.svh"

module wts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  wts_pkg::sts_t sts,
  output wts_pkg::cmd_t cmd
);
  import wts_pkg::*;

  st_t state_r;
  st_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = sts.in_rec ? ST_WRITE : ST_SCAN;
        end
      end
      ST_WRITE: begin
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (sts.last_slot) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
      end
      ST_SCAN: begin
        cmd.read = 1'b1;
      end
      ST_DONE: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `WTS_ASSERT(a_out_load_free, clk, rst_n, cmd.out_load |-> sts.out_free, "output loaded while full")
  `WTS_ASSERT(a_query_scans, clk, rst_n, (in_tvalid && in_tready && !sts.in_rec) |=> (state_r == ST_SCAN), "query did not start a scan")
  `WTS_ASSERT(a_scan_len, clk, rst_n, (state_r == ST_SCAN && !sts.last_slot) |=> (state_r == ST_SCAN), "scan left before last slot")

endmodule

FILE: hdl/wts_dp.sv
// datapath: sample memory, valid bits, write pointers, scan accumulators,
// average multiplier and output register; depends on wts_pkg and the assert header
`include "windowed_tick_statistics_assert.svh"

module wts_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [wts_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [wts_pkg::OP_W-1:0]          in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [wts_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tuser,
  input  wts_pkg::cmd_t                     cmd,
  output wts_pkg::sts_t                     sts
);
  import wts_pkg::*;

  // captured word
  op_t               op_r;
  logic [CAT_W-1:0]  cat_r;
  logic [TICK_W-1:0] ticks_r;

  logic [CAT_IDX_W-1:0] cat_idx;
  logic                 cat_ok;

  // ring storage
  logic [TICK_W-1:0]    mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] slot_valid_r;
  logic [PTR_W-1:0]     wp_r [CATEGORIES];

  logic [ADDR_W-1:0] base_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [PTR_W-1:0]  wp_cur;

  // scan
  logic [PTR_W-1:0]  k_r;
  logic [TICK_W-1:0] rd_data_r;
  logic              rd_vld_r;

  logic [SUM_W-1:0]  sum_r;
  logic [TICK_W-1:0] min_r;
  logic [TICK_W-1:0] max_r;
  logic              any_r;
  logic [PROD_W-1:0] prod_r;

  logic [TICK_W-1:0] stat;

  logic              out_valid_r;
  logic [TICK_W-1:0] out_stat_r;
  logic              out_none_r;

  assign cat_idx   = CAT_IDX_W'(cat_r);
  assign cat_ok    = (32'(cat_r) < CATEGORIES);
  assign base_addr = ADDR_W'(cat_idx) * ADDR_W'(WINDOW);
  assign wp_cur    = wp_r[cat_idx];
  assign wr_addr   = base_addr + ADDR_W'(wp_cur);
  assign rd_addr   = base_addr + ADDR_W'(k_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op_t'(in_tuser);
      cat_r   <= in_tdata[CAT_W-1:0];
      ticks_r <= in_tdata[CAT_W +: TICK_W];
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.write && cat_ok) begin
      mem[wr_addr] <= ticks_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      for (int c = 0; c < CATEGORIES; c++) begin
        wp_r[c] <= '0;
      end
    end else if (cmd.write && cat_ok) begin
      slot_valid_r[wr_addr] <= 1'b1;
      wp_r[cat_idx] <= (wp_cur == PTR_W'(WINDOW - 1)) ? '0 : wp_cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r      <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.read && cat_ok && slot_valid_r[rd_addr];
      if (cmd.load) begin
        k_r <= '0;
      end else if (cmd.read) begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  // one add and two compares per slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      any_r <= 1'b0;
    end else if (cmd.load) begin
      sum_r <= '0;
      any_r <= 1'b0;
    end else if (rd_vld_r) begin
      sum_r <= sum_r + SUM_W'(rd_data_r);
      any_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      if (!any_r || rd_data_r < min_r) begin
        min_r <= rd_data_r;
      end
      if (!any_r || rd_data_r > max_r) begin
        max_r <= rd_data_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(sum_r) * PROD_W'(RECIP);
  end

  always_comb begin
    case (op_r)
      OP_MIN:  stat = any_r ? min_r : '0;
      OP_MAX:  stat = any_r ? max_r : '0;
      OP_AVG:  stat = prod_r[RECIP_SHIFT +: TICK_W];
      default: stat = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_stat_r <= stat;
      out_none_r <= !any_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_stat_r);
  assign out_tuser  = out_none_r;

  assign sts.in_rec    = (op_t'(in_tuser) == OP_RECORD);
  assign sts.last_slot = (k_r == PTR_W'(WINDOW - 1));
  assign sts.out_free  = !out_valid_r || out_tready;

  `WTS_ASSERT(a_empty_sum, clk, rst_n, !any_r |-> (sum_r == '0), "sum nonzero with no valid slot")
  `WTS_ASSERT(a_write_marks, clk, rst_n, (cmd.write && cat_ok) |=> slot_valid_r[$past(wr_addr)], "written slot not marked valid")
  `WTS_ASSERT_ALWAYS(a_rst_out, clk, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule

FILE: hdl/windowed_tick_statistics.sv
// top level of the windowed tick statistics block
// depends on wts_pkg, wts_ctrl and wts_dp
//
//  channel | dir | tdata                                   | tuser
//  in_     | in  | [2:0] category, [18:3] ticks, pad to 24 | [1:0] opcode
//  out_    | out | [15:0] stat_value                       | [0] no_samples
//
// a record is captured, then written to memory, and gives no word
// after its word is captured, a query makes WINDOW slot reads, one per cycle through
// the single memory read port, then drain, average multiply and load; the load waits
// while the output register still holds a word that out_tready has not taken
// the input is taken again the cycle after the result enters the output register,
// even while that word still waits on out_tready
// rst_n clears all valid bits and write pointers at once; no clearing pass
module windowed_tick_statistics (
  input  logic                              clk,
  input  logic                              rst_n,
  // input words
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [wts_pkg::IN_DATA_W-1:0]     in_tdata,  // category, ticks
  input  logic [wts_pkg::OP_W-1:0]          in_tuser,  // opcode
  // result words
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [wts_pkg::OUT_DATA_W-1:0]    out_tdata, // stat_value
  output logic                              out_tuser  // no_samples
);
  import wts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing of capture, write, scan and result load
  wts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // storage, accumulators and output register
  wts_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

FILE: test/windowed_tick_statistics_checker.sv
// result checker for the windowed tick statistics block: watches both word channels,
// keeps its own copy of the sample rings and compares every result word in order
// depends on wts_pkg
module windowed_tick_statistics_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [wts_pkg::IN_DATA_W-1:0]  in_tdata,  // category, ticks
  input  logic [wts_pkg::OP_W-1:0]       in_tuser,  // opcode
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [wts_pkg::OUT_DATA_W-1:0] out_tdata, // stat_value
  input  logic                           out_tuser, // no_samples
  output int unsigned                    mismatch_count,
  output int unsigned                    pending_count
);
  import wts_pkg::*;

  typedef struct packed {
    logic [TICK_W-1:0] stat_value;
    logic              no_samples;
  } stat_word_t;

  logic [TICK_W-1:0] ring_ticks  [CATEGORIES][WINDOW];
  logic              ring_filled [CATEGORIES][WINDOW];
  logic [PTR_W-1:0]  next_slot   [CATEGORIES];
  stat_word_t        expected_stats [$];
  int unsigned       fail_total = 0;

  // min and max over filled slots, average over the whole window
  function automatic stat_word_t predict_stat(input int unsigned cat, input op_t op);
    logic [SUM_W-1:0]  sum;
    logic [TICK_W-1:0] lo;
    logic [TICK_W-1:0] hi;
    bit                any;
    stat_word_t        w;
    sum = '0;
    lo  = '0;
    hi  = '0;
    any = 1'b0;
    if (cat >= CATEGORIES) begin
      w.stat_value = '0;
      w.no_samples = 1'b1;
      return w;
    end
    for (int k = 0; k < WINDOW; k++) begin
      if (ring_filled[cat][k]) begin
        sum = sum + SUM_W'(ring_ticks[cat][k]);
        if (!any || ring_ticks[cat][k] < lo) lo = ring_ticks[cat][k];
        if (!any || ring_ticks[cat][k] > hi) hi = ring_ticks[cat][k];
        any = 1'b1;
      end
    end
    case (op)
      OP_MIN:  w.stat_value = any ? lo : '0;
      OP_MAX:  w.stat_value = any ? hi : '0;
      default: w.stat_value = TICK_W'(sum / WINDOW);
    endcase
    w.no_samples = !any;
    return w;
  endfunction

  always @(posedge clk) begin : watch
    stat_word_t        seen;
    stat_word_t        want;
    op_t               op;
    int unsigned       cat;
    logic [TICK_W-1:0] ticks;
    if (!rst_n) begin
      for (int c = 0; c < CATEGORIES; c++) begin
        next_slot[c] = '0;
        for (int k = 0; k < WINDOW; k++) ring_filled[c][k] = 1'b0;
      end
      expected_stats.delete();
    end else begin
      // results first: a word taken at this edge cannot answer one accepted now
      if (out_tvalid && out_tready) begin
        seen.stat_value = out_tdata[TICK_W-1:0];
        seen.no_samples = out_tuser;
        if (expected_stats.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("unexpected result word: stat_value %0d no_samples %0b",
                     seen.stat_value, seen.no_samples);
        end else begin
          want = expected_stats.pop_front();
          if (seen.stat_value !== want.stat_value || seen.no_samples !== want.no_samples) begin
            fail_total++;
            if (fail_total <= 10)
              $display("result word differs: expected %0d %0b, got %0d %0b",
                       want.stat_value, want.no_samples, seen.stat_value, seen.no_samples);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        cat   = 32'(in_tdata[CAT_W-1:0]);
        ticks = in_tdata[CAT_W +: TICK_W];
        op    = op_t'(in_tuser);
        if (op == OP_RECORD) begin
          if (cat < CATEGORIES) begin
            ring_ticks[cat][next_slot[cat]]  = ticks;
            ring_filled[cat][next_slot[cat]] = 1'b1;
            next_slot[cat] = (next_slot[cat] == PTR_W'(WINDOW - 1)) ?
                             '0 : next_slot[cat] + 1'b1;
          end
        end else begin
          expected_stats.push_back(predict_stat(cat, op));
        end
      end
    end
    pending_count  <= expected_stats.size();
    mismatch_count <= fail_total;
  end

endmodule

FILE: test/windowed_tick_statistics_tb.sv
// top of the windowed tick statistics testbench: clock, reset, word stimulus and verdict
// depends on wts_pkg, windowed_tick_statistics and windowed_tick_statistics_checker
module windowed_tick_statistics_tb;
  import wts_pkg::*;

  // random words per idling phase
  localparam int unsigned PHASE_WORDS = 380;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [OP_W-1:0]       in_tuser   = '0;
  logic                  out_tready = 1'b0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  int unsigned mismatch_count;
  int unsigned pending_count;

  // percent of cycles each side holds back
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int unsigned words_sent  = 0;

  always #4 clk = ~clk;

  windowed_tick_statistics u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // category, ticks, zero pad
    .in_tuser   (in_tuser),   // opcode
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // stat_value
    .out_tuser  (out_tuser)   // no_samples
  );

  windowed_tick_statistics_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // receiver stalls are drawn fresh every cycle, so they land on any phase of a scan
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // offer one word, with a random gap in front, and hold it until taken
  task automatic send_word(input op_t op, input logic [CAT_W-1:0] cat,
                           input logic [TICK_W-1:0] ticks);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_DATA_W'({ticks, cat});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // stop offering until every query has been answered
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // durations leaning toward the edges of the range
  function automatic logic [TICK_W-1:0] pick_ticks();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return {TICK_W{1'b1}};
      2:       return TICK_W'($urandom_range(0, 15));
      3:       return TICK_W'(1) << $urandom_range(0, TICK_W - 1);
      default: return TICK_W'($urandom);
    endcase
  endfunction

  task automatic run_phase(input int tx_pct, input int rx_pct, input int unsigned count);
    int unsigned       stop_at;
    int unsigned       burst;
    logic [CAT_W-1:0]  cat;
    logic [TICK_W-1:0] fill;
    bit                constant_fill;
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          // a run of records into one ring, then queries on it; sometimes the
          // whole window gets one extreme value so the average hits its bounds
          cat           = CAT_W'($urandom_range(0, (1 << CAT_W) - 1));
          constant_fill = ($urandom_range(0, 5) == 0);
          fill          = ($urandom_range(0, 1) == 1) ? {TICK_W{1'b1}} : '0;
          burst         = constant_fill ? WINDOW : $urandom_range(1, WINDOW + 4);
          repeat (burst) send_word(OP_RECORD, cat, constant_fill ? fill : pick_ticks());
          repeat ($urandom_range(1, 3)) send_word(op_t'($urandom_range(1, 3)), cat, pick_ticks());
        end
        7, 8: begin
          // noise: any word at all
          send_word(op_t'($urandom_range(0, 3)),
                    CAT_W'($urandom_range(0, (1 << CAT_W) - 1)),
                    TICK_W'($urandom));
        end
        default: begin
          // broken run: queries on a neighbor ring cut into the records
          cat = CAT_W'($urandom_range(0, (1 << CAT_W) - 1));
          repeat ($urandom_range(2, 6)) begin
            send_word(OP_RECORD, cat, pick_ticks());
            send_word(op_t'($urandom_range(1, 3)), cat + 1'b1, pick_ticks());
          end
        end
      endcase
      if ($urandom_range(0, 39) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_pct = 31;
    rx_idle_pct <= 62;

    // empty ring: all three statistics report no samples
    send_word(OP_MIN, 3'd0, '0);
    send_word(OP_AVG, 3'd0, '0);
    send_word(OP_MAX, 3'd0, {TICK_W{1'b1}});
    // both extremes of the duration in one ring, average over the full window
    send_word(OP_RECORD, 3'd7, '0);
    send_word(OP_RECORD, 3'd7, {TICK_W{1'b1}});
    send_word(OP_MIN, 3'd7, '0);
    send_word(OP_AVG, 3'd7, '0);
    send_word(OP_MAX, 3'd7, '0);
    // alternating bit patterns
    send_word(OP_RECORD, 3'd3, 16'h5555);
    send_word(OP_RECORD, 3'd3, 16'hAAAA);
    send_word(OP_MIN, 3'd3, 16'hAAAA);
    send_word(OP_MAX, 3'd3, 16'h5555);
    send_word(OP_AVG, 3'd3, '0);
    // a lone sample, average truncates to zero
    send_word(OP_RECORD, 3'd0, 16'd1);
    send_word(OP_MIN, 3'd0, '0);
    send_word(OP_MAX, 3'd0, '0);
    send_word(OP_AVG, 3'd0, '0);
    wait_for_results();

    run_phase(31, 62, PHASE_WORDS);
    run_phase(62, 31, PHASE_WORDS);
    run_phase(0, 0, PHASE_WORDS);

    // a last record may still be in its write cycle
    repeat (2 * WINDOW) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
